@@ rtl/sha1sh_pkg.sv @@
// shared constants, control structs and a helper function of the sha-1 stream hasher
package sha1sh_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned NUM_H   = 5;
  localparam int unsigned WIN_LEN = 16;

  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] LAST_POS   = 6'd63;
  localparam logic [2:0] LAST_INDEX = 3'd4;
  localparam logic [7:0] PAD_BYTE   = 8'h80;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [31:0] IV [NUM_H] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // schedule window control
  typedef struct packed {
    logic       push;
    logic       step;
    logic [7:0] push_byte;
  } sched_ctl_t;

  // round unit control
  typedef struct packed {
    logic       load;
    logic       step;
    logic [6:0] rnd;
  } round_ctl_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (WORD_W - n));
  endfunction

endpackage

@@ rtl/sha1sh_if.sv @@
// handshake channels: message bytes in, digest words out
interface sha1sh_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       start_message;
  logic       end_message;

  modport source (output valid, data_byte, has_byte, start_message, end_message,
                  input ready);
  modport sink   (input valid, data_byte, has_byte, start_message, end_message,
                  output ready);
endinterface

interface sha1sh_dig_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ rtl/sha1sh_sched.sv @@
// block buffer and message schedule window, one 16-word shift line
module sha1sh_sched (
  input  logic                   clk,
  input  sha1sh_pkg::sched_ctl_t ctl,
  output logic [31:0]            w0
);
  import sha1sh_pkg::*;

  logic [31:0] win      [WIN_LEN];
  logic [31:0] win_next [WIN_LEN];
  logic [31:0] expand;

  assign expand = rotl32(win[13] ^ win[8] ^ win[2] ^ win[0], 1);
  assign w0     = win[0];

  always_comb begin
    for (int i = 0; i < WIN_LEN; i++) begin
      win_next[i] = win[i];
    end
    if (ctl.push) begin
      // bytes enter at the tail, the oldest byte ends up in the top of word 0
      for (int i = 0; i < WIN_LEN - 1; i++) begin
        win_next[i] = {win[i][23:0], win[i + 1][31:24]};
      end
      win_next[WIN_LEN - 1] = {win[WIN_LEN - 1][23:0], ctl.push_byte};
    end else if (ctl.step) begin
      for (int i = 0; i < WIN_LEN - 1; i++) begin
        win_next[i] = win[i + 1];
      end
      win_next[WIN_LEN - 1] = expand;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < WIN_LEN; i++) begin
      win[i] <= win_next[i];
    end
  end

endmodule

@@ rtl/sha1sh_round.sv @@
// shared sha-1 round unit with its five working registers
module sha1sh_round (
  input  logic                   clk,
  input  sha1sh_pkg::round_ctl_t ctl,
  input  logic [31:0]            h [sha1sh_pkg::NUM_H],
  input  logic [31:0]            w,
  output logic [31:0]            v [sha1sh_pkg::NUM_H]
);
  import sha1sh_pkg::*;

  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] t;

  always_comb begin
    if (ctl.rnd inside {[7'd0:7'd19]}) begin
      f = (v[1] & v[2]) | (~v[1] & v[3]);
      k = K0;
    end else if (ctl.rnd inside {[7'd20:7'd39]}) begin
      f = v[1] ^ v[2] ^ v[3];
      k = K1;
    end else if (ctl.rnd inside {[7'd40:7'd59]}) begin
      f = (v[1] & v[2]) | (v[1] & v[3]) | (v[2] & v[3]);
      k = K2;
    end else begin
      f = v[1] ^ v[2] ^ v[3];
      k = K3;
    end
    t = rotl32(v[0], 5) + f + v[4] + k + w;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int i = 0; i < NUM_H; i++) begin
        v[i] <= h[i];
      end
    end else if (ctl.step) begin
      v[0] <= t;
      v[1] <= v[0];
      v[2] <= rotl32(v[1], 30);
      v[3] <= v[2];
      v[4] <= v[3];
    end
  end

endmodule

@@ rtl/sha1_stream_hasher_core.sv @@
// top level: sequencer, hash words, length counter and digest output register
//
// channel  | dir  | payload
// msg      | sink | data_byte[7:0], has_byte, start_message, end_message
// digest   | src  | digest_word[31:0], word_index[2:0], last_word
//
// a byte item is pushed into the block; the item that fills a 64-byte block also runs
// the 80 rounds through the one round unit, then the hash update
// an end item pushes its padding bytes (9 to 72), runs the rounds and the hash
// update for each padded block, then outputs the five digest words
// rst is synchronous and restores the initial hash words and a zero length
// msg.ready is low while a block or digest is in progress; a stalled digest
// word holds in the output register
module sha1_stream_hasher_core (
  input  logic         clk,
  input  logic         rst,
  sha1sh_msg_if.sink   msg,
  sha1sh_dig_if.source digest
);
  import sha1sh_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_FINAL = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t      state, state_next;
  logic [31:0] h      [NUM_H];
  logic [31:0] h_next [NUM_H];
  logic [31:0] v      [NUM_H];
  logic [63:0] count, count_next;
  logic [63:0] cnt_base;
  logic [63:0] len_bits, len_bits_next;
  logic [5:0]  fill, fill_next;
  logic [5:0]  fill_base;
  logic [6:0]  rnd, rnd_next;
  logic [2:0]  emit_idx, emit_idx_next;
  logic        finishing, finishing_next;
  logic        sent80, sent80_next;
  logic        extra, extra_next;
  logic        out_valid, out_valid_next;
  logic [31:0] out_word, out_word_next;
  logic [2:0]  out_index, out_index_next;
  logic        out_last, out_last_next;
  logic        accept;
  logic [31:0] w0;

  sched_ctl_t  sched_ctl;
  round_ctl_t  round_ctl;

  assign msg.ready          = (state == ST_IDLE);
  assign accept             = msg.valid && msg.ready;
  assign digest.valid       = out_valid;
  assign digest.digest_word = out_word;
  assign digest.word_index  = out_index;
  assign digest.last_word   = out_last;

  sha1sh_sched u_sched (
    .clk (clk),
    .ctl (sched_ctl),
    .w0  (w0)
  );

  sha1sh_round u_round (
    .clk (clk),
    .ctl (round_ctl),
    .h   (h),
    .w   (w0),
    .v   (v)
  );

  always_comb begin
    state_next     = state;
    count_next     = count;
    len_bits_next  = len_bits;
    fill_next      = fill;
    rnd_next       = rnd;
    emit_idx_next  = emit_idx;
    finishing_next = finishing;
    sent80_next    = sent80;
    extra_next     = extra;
    out_valid_next = out_valid;
    out_word_next  = out_word;
    out_index_next = out_index;
    out_last_next  = out_last;
    for (int i = 0; i < NUM_H; i++) begin
      h_next[i] = h[i];
    end
    cnt_base  = msg.start_message ? 64'd0 : count;
    fill_base = msg.start_message ? 6'd0 : fill;

    sched_ctl.push      = 1'b0;
    sched_ctl.step      = 1'b0;
    sched_ctl.push_byte = msg.data_byte;
    // working registers track the hash words until the rounds begin
    round_ctl.load      = (state != ST_ROUND);
    round_ctl.step      = (state == ST_ROUND);
    round_ctl.rnd       = rnd;

    if (digest.ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        if (accept) begin
          count_next = cnt_base;
          fill_next  = fill_base;
          if (msg.start_message) begin
            for (int i = 0; i < NUM_H; i++) begin
              h_next[i] = IV[i];
            end
          end
          if (msg.has_byte) begin
            sched_ctl.push = 1'b1;
            count_next     = cnt_base + 64'd1;
            fill_next      = fill_base + 6'd1;
          end
          if (msg.end_message) begin
            finishing_next = 1'b1;
            sent80_next    = 1'b0;
            extra_next     = 1'b0;
            len_bits_next  = (msg.has_byte ? cnt_base + 64'd1 : cnt_base) << 3;
          end
          if (msg.has_byte && fill_base == LAST_POS) begin
            state_next = ST_ROUND;
            rnd_next   = 7'd0;
          end else if (msg.end_message) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        sched_ctl.push = 1'b1;
        if (!sent80) begin
          sched_ctl.push_byte = PAD_BYTE;
          sent80_next         = 1'b1;
          // no room left for the length in this block
          extra_next          = (fill >= LEN_POS);
        end else if (fill < LEN_POS || extra) begin
          sched_ctl.push_byte = 8'h00;
        end else begin
          sched_ctl.push_byte = len_bits[63:56];
          len_bits_next       = len_bits << 8;
        end
        fill_next = fill + 6'd1;
        if (fill == LAST_POS) begin
          state_next = ST_ROUND;
          rnd_next   = 7'd0;
        end
      end
      ST_ROUND: begin
        sched_ctl.step = 1'b1;
        rnd_next       = rnd + 7'd1;
        if (rnd == LAST_ROUND) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        for (int i = 0; i < NUM_H; i++) begin
          h_next[i] = h[i] + v[i];
        end
        extra_next = 1'b0;
        if (!finishing) begin
          state_next = ST_IDLE;
        end else if (!sent80 || extra) begin
          state_next = ST_PAD;
        end else begin
          state_next    = ST_EMIT;
          emit_idx_next = 3'd0;
        end
      end
      ST_EMIT: begin
        if (!out_valid || digest.ready) begin
          out_valid_next = 1'b1;
          out_word_next  = h[emit_idx];
          out_index_next = emit_idx;
          out_last_next  = (emit_idx == LAST_INDEX);
          emit_idx_next  = emit_idx + 3'd1;
          if (emit_idx == LAST_INDEX) begin
            // last digest word issued: next bytes open a new message
            for (int i = 0; i < NUM_H; i++) begin
              h_next[i] = IV[i];
            end
            count_next     = 64'd0;
            fill_next      = 6'd0;
            finishing_next = 1'b0;
            state_next     = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= 64'd0;
      fill      <= 6'd0;
      finishing <= 1'b0;
      sent80    <= 1'b0;
      extra     <= 1'b0;
      out_valid <= 1'b0;
      rnd       <= 7'd0;
      emit_idx  <= 3'd0;
      for (int i = 0; i < NUM_H; i++) begin
        h[i] <= IV[i];
      end
    end else begin
      state     <= state_next;
      count     <= count_next;
      fill      <= fill_next;
      finishing <= finishing_next;
      sent80    <= sent80_next;
      extra     <= extra_next;
      out_valid <= out_valid_next;
      rnd       <= rnd_next;
      emit_idx  <= emit_idx_next;
      for (int i = 0; i < NUM_H; i++) begin
        h[i] <= h_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    len_bits  <= len_bits_next;
    out_word  <= out_word_next;
    out_index <= out_index_next;
    out_last  <= out_last_next;
  end

endmodule

@@ test/tb_top.sv @@
// testbench for the sha-1 stream hasher: random message streams checked against a sha-1 predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET  = 400;
  localparam int CALM_ITEMS   = 60;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 250;
  localparam int DIGEST_WORDS = 5;

  localparam bit [31:0] H_INIT0 = 32'h67452301;
  localparam bit [31:0] H_INIT1 = 32'hEFCDAB89;
  localparam bit [31:0] H_INIT2 = 32'h98BADCFE;
  localparam bit [31:0] H_INIT3 = 32'h10325476;
  localparam bit [31:0] H_INIT4 = 32'hC3D2E1F0;
  localparam bit [31:0] K_CHOOSE = 32'h5A827999;
  localparam bit [31:0] K_PARITY = 32'h6ED9EBA1;
  localparam bit [31:0] K_MAJOR  = 32'h8F1BBCDC;
  localparam bit [31:0] K_LATE   = 32'hCA62C1D6;
  localparam bit [7:0]  PAD_MARK = 8'h80;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  word_idx;
    logic        last;
  } digest_word_t;

  class sha1_digest_board;
    bit [31:0]    chain[DIGEST_WORDS];
    bit [63:0]    byte_total;
    bit [7:0]     block_bytes[64];
    digest_word_t pending_words[$];
    int           mismatches;
    int           words_checked;
    int           digests;
    int           long_pads;

    function new();
      restart();
      mismatches    = 0;
      words_checked = 0;
      digests       = 0;
      long_pads     = 0;
    endfunction

    static function bit [31:0] rotl(bit [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
    endfunction

    function void restart();
      chain[0]   = H_INIT0;
      chain[1]   = H_INIT1;
      chain[2]   = H_INIT2;
      chain[3]   = H_INIT3;
      chain[4]   = H_INIT4;
      byte_total = '0;
    endfunction

    function void compress();
      bit [31:0] w[16];
      bit [31:0] a, b, c, d, e, f, k, t, wv;
      int r;
      for (r = 0; r < 16; r++)
        w[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2], block_bytes[4*r+3]};
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (r = 0; r < 80; r++) begin
        if (r < 16) begin
          wv = w[r];
        end else begin
          wv = rotl(w[(r+13)%16] ^ w[(r+8)%16] ^ w[(r+2)%16] ^ w[r%16], 1);
          w[r%16] = wv;
        end
        if (r < 20) begin
          f = (b & c) | (~b & d);
          k = K_CHOOSE;
        end else if (r < 40) begin
          f = b ^ c ^ d;
          k = K_PARITY;
        end else if (r < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = K_MAJOR;
        end else begin
          f = b ^ c ^ d;
          k = K_LATE;
        end
        t = rotl(a, 5) + f + e + k + wv;
        e = d;
        d = c;
        c = rotl(b, 30);
        b = a;
        a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
    endfunction

    // start first, then the byte, then the end of message
    function void note_item(bit [7:0] data, bit has, bit start, bit last_item);
      int pos;
      int i;
      bit [63:0] bit_len;
      digest_word_t rec;
      if (start)
        restart();
      if (has) begin
        pos = int'(byte_total[5:0]);
        block_bytes[pos] = data;
        byte_total++;
        if (pos == 63)
          compress();
      end
      if (!last_item)
        return;
      digests++;
      bit_len = byte_total << 3;
      pos = int'(byte_total[5:0]);
      block_bytes[pos] = PAD_MARK;
      pos++;
      // no room left for the length: pad out and compress an extra block
      if (pos > 56) begin
        long_pads++;
        while (pos < 64) begin
          block_bytes[pos] = 8'h00;
          pos++;
        end
        compress();
        pos = 0;
      end
      while (pos < 56) begin
        block_bytes[pos] = 8'h00;
        pos++;
      end
      for (i = 0; i < 8; i++)
        block_bytes[56+i] = bit_len[63-8*i -: 8];
      compress();
      for (i = 0; i < DIGEST_WORDS; i++) begin
        rec.word     = chain[i];
        rec.word_idx = 3'(i);
        rec.last     = (i == DIGEST_WORDS - 1);
        pending_words.push_back(rec);
      end
      restart();
    endfunction

    function void check_word(logic [31:0] word, logic [2:0] word_idx, logic last);
      digest_word_t want;
      words_checked++;
      if (pending_words.size() == 0) begin
        mismatches++;
        $display("%0t: digest word %h index %0d arrived with no digest pending",
                 $time, word, word_idx);
        return;
      end
      want = pending_words.pop_front();
      if (word !== want.word) begin
        mismatches++;
        $display("%0t: digest_word expected %h actual %h", $time, want.word, word);
      end
      if (word_idx !== want.word_idx) begin
        mismatches++;
        $display("%0t: word_index expected %0d actual %0d", $time, want.word_idx, word_idx);
      end
      if (last !== want.last) begin
        mismatches++;
        $display("%0t: last_word expected %0b actual %0b", $time, want.last, last);
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;

  sha1sh_msg_if msg_ch ();
  sha1sh_dig_if dig_ch ();

  sha1_stream_hasher_core dut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_ch),
    .digest (dig_ch)
  );

  sha1_digest_board board = new();

  int items_sent     = 0;
  bit calm           = 1'b0;
  bit tx_gaps_on     = 1'b1;
  bit hold_requested = 1'b0;
  bit hold_over      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    msg_ch.valid         <= 1'b0;
    msg_ch.data_byte     <= 8'h00;
    msg_ch.has_byte      <= 1'b0;
    msg_ch.start_message <= 1'b0;
    msg_ch.end_message   <= 1'b0;
    dig_ch.ready         <= 1'b0;
  end

  task automatic send_item(input logic [7:0] data, input logic has, input logic start,
                           input logic last_item);
    msg_ch.valid         <= 1'b1;
    msg_ch.data_byte     <= data;
    msg_ch.has_byte      <= has;
    msg_ch.start_message <= start;
    msg_ch.end_message   <= last_item;
    @(posedge clk);
    while (!msg_ch.ready) @(posedge clk);
    board.note_item(data, has, start, last_item);
    if (has || last_item)
      items_sent++;
    if (!calm && tx_gaps_on && $urandom_range(0, 3) == 0) begin
      msg_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic send_message(input int len, input bit lead_start);
    int k;
    bit split_end;
    split_end = (len == 0) || ($urandom_range(0, 1) == 1);
    for (k = 0; k < len; k++) begin
      // occasional empty item that the block should ignore
      if ($urandom_range(0, 39) == 0)
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1,
                (k == 0 && lead_start) || ($urandom_range(0, 59) == 0),
                !split_end && (k == len - 1));
    end
    if (split_end)
      send_item(8'($urandom_range(0, 255)), 1'b0, lead_start && (len == 0), 1'b1);
  endtask

  // stimulus
  initial begin
    int len;
    int pick;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty messages, start and end together, restart mid-message
    send_item(8'h00, 1'b0, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0, 1'b0);
    send_item(8'h63, 1'b1, 1'b0, 1'b1);
    send_item(8'h55, 1'b1, 1'b0, 1'b0);
    send_item(8'hAA, 1'b1, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0, 1'b1);
    send_item(8'h01, 1'b1, 1'b1, 1'b0);
    send_item(8'h02, 1'b1, 1'b0, 1'b0);
    send_item(8'h03, 1'b1, 1'b1, 1'b0);
    send_item(8'h04, 1'b1, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0, 1'b1);

    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= HOLD_AT)
        hold_requested = 1'b1;
      if (items_sent >= ITEM_TARGET - CALM_ITEMS)
        calm = 1'b1;
      if ($urandom_range(0, 4) == 0)
        tx_gaps_on = !tx_gaps_on;
      pick = $urandom_range(0, 11);
      // short messages while the digest side is held off so the block backs up
      if (hold_requested && !hold_over)
        len = $urandom_range(0, 3);
      else if (pick < 9)
        len = $urandom_range(0, 12);
      else if (pick < 11)
        len = $urandom_range(52, 66);
      else
        len = $urandom_range(116, 124);
      send_message(len, $urandom_range(0, 3) != 0);
    end
    msg_ch.valid <= 1'b0;

    while (board.pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d message items sent, %0d digests, %0d of them padded with an extra block",
             items_sent, board.digests, board.long_pads);
    $display("%0d digest words checked, one hold-off of %0d cycles on the digest side",
             board.words_checked, HOLD_CYCLES);
    if (board.mismatches == 0 && board.pending_words.size() == 0)
      $display("sha1_stream_hasher_core: match");
    else
      $display("sha1_stream_hasher_core: mismatch");
    $finish;
  end

  // digest receiver
  initial begin
    int stall_left;
    int hold_left;
    bit hold_begun;
    bit rx_gaps_on;
    stall_left = 0;
    hold_left  = 0;
    hold_begun = 1'b0;
    rx_gaps_on = 1'b1;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (dig_ch.valid && dig_ch.ready)
        board.check_word(dig_ch.digest_word, dig_ch.word_index, dig_ch.last_word);
      if (hold_requested && !hold_begun) begin
        hold_begun = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        if (hold_left == 0)
          hold_over = 1'b1;
        dig_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        dig_ch.ready <= 1'b0;
      end else begin
        if ($urandom_range(0, 19) == 0)
          rx_gaps_on = !rx_gaps_on;
        if (!calm && rx_gaps_on && $urandom_range(0, 4) == 0) begin
          stall_left = $urandom_range(0, 7);
          dig_ch.ready <= 1'b0;
        end else begin
          dig_ch.ready <= 1'b1;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((msg_ch.valid && msg_ch.ready) || (dig_ch.valid && dig_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("sha1_stream_hasher_core: mismatch");
        $finish;
      end
    end
  end

endmodule
